// ----- rtl/acvt_pkg.sv -----
package acvt_pkg;

   // field widths
   localparam int ADC_W    = 12;
   localparam int MODE_W   = 2;
   localparam int MV_OUT_W = 12;
   localparam int TEXT_W   = 6;
   localparam int UNIT_W   = 7;

   // full scale voltage in millivolts
   localparam int FULL_SCALE_MV = 3300;

   // internal widths derived from the full scale voltage
   localparam int MV_W        = $clog2(FULL_SCALE_MV + 1);
   localparam int P_W         = ADC_W + $clog2(FULL_SCALE_MV + 1);
   localparam int RECIP_SHIFT = P_W;
   localparam int WIDE_W      = 2 * P_W;

   // converter resolution codes
   typedef enum logic [MODE_W-1:0] {
      MODE_6BIT  = 2'd0,
      MODE_8BIT  = 2'd1,
      MODE_10BIT = 2'd2,
      MODE_12BIT = 2'd3
   } acvt_mode_type;

   // full scale codes
   localparam logic [ADC_W-1:0] FS_6BIT  = 12'h03F;
   localparam logic [ADC_W-1:0] FS_8BIT  = 12'h0FF;
   localparam logic [ADC_W-1:0] FS_10BIT = 12'h3FF;
   localparam logic [ADC_W-1:0] FS_12BIT = 12'hFFF;

   // truncated reciprocals of the full scale codes, scaled by 2^RECIP_SHIFT
   localparam logic [P_W-1:0] RECIP_6BIT  = P_W'((64'd1 << RECIP_SHIFT) / 64'd63);
   localparam logic [P_W-1:0] RECIP_8BIT  = P_W'((64'd1 << RECIP_SHIFT) / 64'd255);
   localparam logic [P_W-1:0] RECIP_10BIT = P_W'((64'd1 << RECIP_SHIFT) / 64'd1023);
   localparam logic [P_W-1:0] RECIP_12BIT = P_W'((64'd1 << RECIP_SHIFT) / 64'd4095);

   // decimal digit extraction, exact for values below 10000
   localparam int              DIG_W        = 14;
   localparam int              DIG_PROD_W   = 30;
   localparam logic [15:0]     DIV1000_MUL  = 16'd16778;
   localparam int              DIV1000_SH   = 24;
   localparam logic [15:0]     DIV100_MUL   = 16'd5243;
   localparam int              DIV100_SH    = 19;
   localparam logic [15:0]     DIV10_MUL    = 16'd52429;
   localparam int              DIV10_SH     = 19;

   // ascii codes
   localparam logic [TEXT_W-1:0] DIGIT_CHAR_BASE = 6'h30;
   localparam logic [TEXT_W-1:0] ASCII_POINT     = 6'h2E;
   localparam logic [UNIT_W-1:0] ASCII_V         = 7'h56;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified transaction
   typedef struct packed {
      logic [ADC_W-1:0] code;
      acvt_mode_type    mode;
      logic             sat;
   } acvt_item_type;

   function automatic logic [ADC_W-1:0] full_scale(input acvt_mode_type mode);
      logic [ADC_W-1:0] fs;
      case (mode)
         MODE_6BIT:  fs = FS_6BIT;
         MODE_8BIT:  fs = FS_8BIT;
         MODE_10BIT: fs = FS_10BIT;
         MODE_12BIT: fs = FS_12BIT;
         default:    fs = FS_6BIT;
      endcase
      return fs;
   endfunction

   function automatic logic [P_W-1:0] recip(input acvt_mode_type mode);
      logic [P_W-1:0] r;
      case (mode)
         MODE_6BIT:  r = RECIP_6BIT;
         MODE_8BIT:  r = RECIP_8BIT;
         MODE_10BIT: r = RECIP_10BIT;
         MODE_12BIT: r = RECIP_12BIT;
         default:    r = RECIP_6BIT;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/acvt_front.sv -----
module acvt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [11:0]           req_adc_code,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_write_data,
   input  logic                  q_full,
   output logic                  q_push,
   output acvt_pkg::acvt_item_type q_item
);
   import acvt_pkg::*;

   acvt_mode_type    resolution_mode_ff;
   acvt_mode_type    resolution_mode_in;
   logic [ADC_W-1:0] fs;

   // resolution register
   always_comb begin
      resolution_mode_in = resolution_mode_ff;
      if (csr_write_enable) begin
         resolution_mode_in = acvt_mode_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_mode_ff <= MODE_6BIT;
      end else begin
         resolution_mode_ff <= resolution_mode_in;
      end
   end

   // classify: tag with resolution and flag codes above full scale
   always_comb begin
      fs          = full_scale(resolution_mode_ff);
      q_item.code = req_adc_code;
      q_item.mode = resolution_mode_ff;
      q_item.sat  = (req_adc_code > fs);
   end

   assign full   = q_full;
   assign q_push = push && !q_full;

endmodule

// ----- rtl/acvt_queue.sv -----
module acvt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  acvt_pkg::acvt_item_type wr_item,
   output logic                    q_full,
   output logic                    q_valid,
   output acvt_pkg::acvt_item_type rd_item,
   input  logic                    rd_en
);
   import acvt_pkg::*;

   acvt_item_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && q_valid;
   assign rd_item = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !q_full && !(rd_en && q_valid)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a write");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

// ----- rtl/acvt_back.sv -----
module acvt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  acvt_pkg::acvt_item_type q_item,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output logic [11:0]             rsp_millivolts,
   output logic [5:0]              rsp_text_volts_digit,
   output logic [5:0]              rsp_text_point,
   output logic [5:0]              rsp_text_tenths,
   output logic [5:0]              rsp_text_hundredths,
   output logic [5:0]              rsp_text_thousandths,
   output logic [6:0]              rsp_text_unit
);
   import acvt_pkg::*;

   // stage valids and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: product
   logic [P_W-1:0]    p1_ff, p1_in;
   acvt_mode_type     m1_ff;
   logic              s1_ff;
   // stage 2: reciprocal estimate
   logic [P_W-1:0]    p2_ff;
   acvt_mode_type     m2_ff;
   logic              s2_ff;
   logic [MV_W-1:0]   q2_ff, q2_in;
   logic [WIDE_W-1:0] wide2;
   // stage 3: corrected quotient
   logic [MV_W-1:0]   mv3_ff, mv3_in;
   logic [P_W-1:0]    rem3;
   logic [ADC_W-1:0]  fs3;
   // stage 4: decimal quotients
   logic [DIG_W-1:0]      x4_ff, x4_in;
   logic [3:0]            th4_ff, th4_in;
   logic [6:0]            hq4_ff, hq4_in;
   logic [9:0]            tq4_ff, tq4_in;
   logic [DIG_PROD_W-1:0] prod1000, prod100, prod10;
   // stage 5: result register
   logic [MV_OUT_W-1:0] mv5_ff, mv5_in;
   logic [TEXT_W-1:0]   th5_ff, th5_in;
   logic [TEXT_W-1:0]   h5_ff, h5_in;
   logic [TEXT_W-1:0]   t5_ff, t5_in;
   logic [TEXT_W-1:0]   u5_ff, u5_in;
   logic [6:0]          h_full;
   logic [9:0]          t_full;
   logic [DIG_W-1:0]    u_full;

   // a stage takes new data when it is empty or its content moves on
   assign rdy5  = !v5_ff || pop;
   assign rdy4  = !v4_ff || rdy5;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign q_pop = q_valid && rdy1;

   always_comb begin
      v1_in = rdy1 ? q_valid : v1_ff;
      v2_in = rdy2 ? v1_ff   : v2_ff;
      v3_in = rdy3 ? v2_ff   : v3_ff;
      v4_in = rdy4 ? v3_ff   : v4_ff;
      v5_in = rdy5 ? v4_ff   : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // stage 1: code times full scale millivolts
   assign p1_in = P_W'(q_item.code) * P_W'(FULL_SCALE_MV);

   always_ff @(posedge clock) begin
      if (rdy1 && q_valid) begin
         p1_ff <= p1_in;
         m1_ff <= q_item.mode;
         s1_ff <= q_item.sat;
      end
   end

   // stage 2: quotient estimate from truncated reciprocal, low by at most one
   assign wide2 = WIDE_W'(p1_ff) * WIDE_W'(recip(m1_ff));
   assign q2_in = wide2[RECIP_SHIFT +: MV_W];

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         p2_ff <= p1_ff;
         m2_ff <= m1_ff;
         s2_ff <= s1_ff;
         q2_ff <= q2_in;
      end
   end

   // stage 3: remainder check and saturation
   always_comb begin
      fs3  = full_scale(m2_ff);
      rem3 = p2_ff - P_W'(q2_ff) * P_W'(fs3);
      if (s2_ff) begin
         mv3_in = MV_W'(FULL_SCALE_MV);
      end else if (rem3 >= P_W'(fs3)) begin
         mv3_in = q2_ff + 1'b1;
      end else begin
         mv3_in = q2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         mv3_ff <= mv3_in;
      end
   end

   // stage 4: value over 1000, 100 and 10 by reciprocal multiply
   always_comb begin
      x4_in    = DIG_W'(mv3_ff);
      prod1000 = DIG_PROD_W'(x4_in) * DIG_PROD_W'(DIV1000_MUL);
      prod100  = DIG_PROD_W'(x4_in) * DIG_PROD_W'(DIV100_MUL);
      prod10   = DIG_PROD_W'(x4_in) * DIG_PROD_W'(DIV10_MUL);
      th4_in   = prod1000[DIV1000_SH +: 4];
      hq4_in   = prod100[DIV100_SH +: 7];
      tq4_in   = prod10[DIV10_SH +: 10];
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         x4_ff  <= x4_in;
         th4_ff <= th4_in;
         hq4_ff <= hq4_in;
         tq4_ff <= tq4_in;
      end
   end

   // stage 5: digits as remainders, then ascii
   always_comb begin
      h_full = hq4_ff - 7'(th4_ff) * 7'd10;
      t_full = tq4_ff - 10'(hq4_ff) * 10'd10;
      u_full = x4_ff - DIG_W'(tq4_ff) * DIG_W'(10);
      mv5_in = MV_OUT_W'(x4_ff);
      th5_in = DIGIT_CHAR_BASE + TEXT_W'(th4_ff);
      h5_in  = DIGIT_CHAR_BASE + TEXT_W'(h_full[3:0]);
      t5_in  = DIGIT_CHAR_BASE + TEXT_W'(t_full[3:0]);
      u5_in  = DIGIT_CHAR_BASE + TEXT_W'(u_full[3:0]);
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         mv5_ff <= mv5_in;
         th5_ff <= th5_in;
         h5_ff  <= h5_in;
         t5_ff  <= t5_in;
         u5_ff  <= u5_in;
      end
   end

   // result ports
   assign empty                = !v5_ff;
   assign rsp_millivolts       = mv5_ff;
   assign rsp_text_volts_digit = th5_ff;
   assign rsp_text_point       = ASCII_POINT;
   assign rsp_text_tenths      = h5_ff;
   assign rsp_text_hundredths  = t5_ff;
   assign rsp_text_thousandths = u5_ff;
   assign rsp_text_unit        = ASCII_V;

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_mv_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (mv3_ff <= MV_W'(FULL_SCALE_MV)))
      else $error("scaled value above full scale");

   a_digits_ascii: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> ((th5_ff >= DIGIT_CHAR_BASE) && (th5_ff <= DIGIT_CHAR_BASE + 6'd9) &&
                 (h5_ff >= DIGIT_CHAR_BASE) && (h5_ff <= DIGIT_CHAR_BASE + 6'd9) &&
                 (t5_ff >= DIGIT_CHAR_BASE) && (t5_ff <= DIGIT_CHAR_BASE + 6'd9) &&
                 (u5_ff >= DIGIT_CHAR_BASE) && (u5_ff <= DIGIT_CHAR_BASE + 6'd9)))
      else $error("digit outside ascii 0 to 9");

endmodule

// ----- rtl/adc_code_to_voltage_text.sv -----
// channel    direction  handshake          payload
// req        in         push / full        req_adc_code
// rsp        out        empty / pop        rsp_millivolts, rsp_text_*
// csr        in         csr_write_enable   csr_write_data (resolution)
//
// one transaction per cycle sustained while results are popped; an accepted code passes
// through a four-entry queue and then the five-stage back pipeline (two multiplies,
// correction, decimal split, result register)
// reset clears the queue and pipeline and selects 6 bit resolution
// a stalled result holds the pipeline; full rises once the queue also fills
module adc_code_to_voltage_text (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [11:0] req_adc_code,
   output logic        empty,
   input  logic        pop,
   output logic [11:0] rsp_millivolts,
   output logic [5:0]  rsp_text_volts_digit,
   output logic [5:0]  rsp_text_point,
   output logic [5:0]  rsp_text_tenths,
   output logic [5:0]  rsp_text_hundredths,
   output logic [5:0]  rsp_text_thousandths,
   output logic [6:0]  rsp_text_unit,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);
   import acvt_pkg::*;

   logic          q_full;
   logic          q_push;
   logic          q_valid;
   logic          q_pop;
   acvt_item_type wr_item;
   acvt_item_type rd_item;

   // front: accept and classify
   acvt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_adc_code     (req_adc_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (wr_item)
   );

   // queue between front and back
   acvt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (wr_item),
      .q_full  (q_full),
      .q_valid (q_valid),
      .rd_item (rd_item),
      .rd_en   (q_pop)
   );

   // back: scale and format
   acvt_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (rd_item),
      .q_pop                (q_pop),
      .empty                (empty),
      .pop                  (pop),
      .rsp_millivolts       (rsp_millivolts),
      .rsp_text_volts_digit (rsp_text_volts_digit),
      .rsp_text_point       (rsp_text_point),
      .rsp_text_tenths      (rsp_text_tenths),
      .rsp_text_hundredths  (rsp_text_hundredths),
      .rsp_text_thousandths (rsp_text_thousandths),
      .rsp_text_unit        (rsp_text_unit)
   );

endmodule
